[hdl/kts_pkg.sv]
// ----------------------------------------------------------------------------
// Key table package
// Shared codes and types for the key table sort and search block.
// ----------------------------------------------------------------------------
`default_nettype none

package kts_pkg;

  localparam int KEY_W   = 32;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;
  localparam int FUNC_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE   = 2'd0,
    FN_SORT    = 2'd1,
    FN_LSEARCH = 2'd2,
    FN_BSEARCH = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_ROTATE = 2'd2,
    OP_SWAP   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     odd_phase;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/kts_chan_if.sv]
// ----------------------------------------------------------------------------
// Key table channel interfaces
// Valid/ready channels for requests, results and the entry count register.
// ----------------------------------------------------------------------------
`default_nettype none

interface kts_req_if;
  logic                           valid;
  logic                           ready;
  logic [kts_pkg::FUNC_W-1:0]     func;
  logic [kts_pkg::INDEX_W-1:0]    entry_index;
  logic signed [kts_pkg::KEY_W-1:0] key;

  modport source (output valid, func, entry_index, key, input ready);
  modport sink   (input valid, func, entry_index, key, output ready);
endinterface

interface kts_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [kts_pkg::INDEX_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

interface kts_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kts_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface

`default_nettype wire

[hdl/kts_cell.sv]
// ----------------------------------------------------------------------------
// Key table cell
// Holds one key. Loads a written key, shifts toward its left neighbor while
// the ring rotates, and takes part in odd-even compare-and-swap phases.
// ----------------------------------------------------------------------------
`default_nettype none

module kts_cell #(
  parameter int IDX   = 0,
  parameter int NW    = 5
) (
  input  wire logic                              clk,
  input  wire kts_pkg::cell_ctrl_t               ctrl,
  input  wire logic [kts_pkg::INDEX_W-1:0]       wr_idx,
  input  wire logic signed [kts_pkg::KEY_W-1:0]  wr_key,
  input  wire logic [NW-1:0]                     n_used,
  input  wire logic signed [kts_pkg::KEY_W-1:0]  left_key,
  input  wire logic                              left_gt,
  input  wire logic signed [kts_pkg::KEY_W-1:0]  right_key,
  output logic signed [kts_pkg::KEY_W-1:0]       key,
  output logic                                   gt
);

  localparam logic PAR = 1'((IDX % 2) == 1);

  logic left_act;
  logic right_act;
  logic wr_hit;

  assign gt        = key > right_key;
  assign left_act  = (ctrl.odd_phase == PAR) && ((IDX + 1) < int'(n_used));
  assign right_act = (IDX >= 1) && (ctrl.odd_phase != PAR) && (IDX < int'(n_used));
  assign wr_hit    = (int'(wr_idx) == IDX);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      kts_pkg::OP_WRITE: begin
        if (wr_hit) begin
          key <= wr_key;
        end
      end
      kts_pkg::OP_ROTATE: begin
        key <= right_key;
      end
      kts_pkg::OP_SWAP: begin
        if (left_act && gt) begin
          key <= right_key;
        end else if (right_act && left_gt) begin
          key <= left_key;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/key_table_sort_and_search.sv]
// ----------------------------------------------------------------------------
// Key table sort and search
// Table of signed keys in a ring of cells with sort, linear and binary search.
// ----------------------------------------------------------------------------
// The req channel carries one command per transaction: write a key at an
// index, sort the used entries, search linearly, or sort and then bisect.
// The cfg channel writes entry_count and is always ready; write it only while
// the block is idle. Searches return one transaction on rsp with found and
// position; writes and sorts return nothing.
// A write loads the addressed cell as the command is accepted. A sort runs
// DEPTH odd-even compare-and-swap phases across the cell row. A linear
// search rotates the ring once past cell 0, then posts the result. A binary
// search sorts first, then rotates the ring until each bisection midpoint
// reaches cell 0. One command is processed at a time; req.ready is high
// only when idle. Results sit in an output register; if rsp stalls and the
// next search finishes, that search waits until the register frees up.
// Reset clears the controller and entry_count; the keys are undefined until
// written.
// ----------------------------------------------------------------------------
`default_nettype none

module key_table_sort_and_search #(
  parameter int DEPTH = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  kts_req_if.sink   req,
  kts_rsp_if.source rsp,
  kts_cfg_if.sink   cfg
);

  localparam int IW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);
  localparam int CW = (NW > kts_pkg::COUNT_W) ? NW : kts_pkg::COUNT_W;
  localparam int BW = NW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_LSCAN,
    ST_BSCAN,
    ST_PUSH
  } state_t;

  state_t                          state;
  logic [kts_pkg::COUNT_W-1:0]     entry_count;
  logic [NW-1:0]                   n_used;
  logic [CW-1:0]                   ec_ext;
  logic [IW-1:0]                   cnt;
  logic [IW-1:0]                   pc;
  logic signed [kts_pkg::KEY_W-1:0] skey;
  logic                            is_bin;
  logic signed [BW-1:0]            low;
  logic signed [BW-1:0]            high;
  logic signed [BW:0]              mid_sum;
  logic signed [BW-1:0]            mid;
  logic                            bdone;
  logic                            res_found;
  logic [kts_pkg::INDEX_W-1:0]     res_pos;
  logic                            out_valid;
  logic                            out_found;
  logic [kts_pkg::INDEX_W-1:0]     out_pos;
  kts_pkg::cell_ctrl_t             ctrl;

  logic signed [kts_pkg::KEY_W-1:0] cell_key [DEPTH];
  logic                             cell_gt  [DEPTH];

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.found    = out_found;
  assign rsp.position = out_pos;

  assign ec_ext = CW'(entry_count);
  assign n_used = (ec_ext > CW'(DEPTH)) ? NW'(DEPTH) : NW'(ec_ext);

  assign mid_sum = {low[BW-1], low} + {high[BW-1], high};
  assign mid     = mid_sum[BW:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg.valid && cfg.ready) begin
      entry_count <= cfg.entry_count;
    end
  end

  always_comb begin
    ctrl.op        = kts_pkg::OP_HOLD;
    ctrl.odd_phase = pc[0];
    unique case (state)
      ST_IDLE: begin
        if (req.valid && (req.func == kts_pkg::FN_WRITE)) begin
          ctrl.op = kts_pkg::OP_WRITE;
        end
      end
      ST_SORT:  ctrl.op = kts_pkg::OP_SWAP;
      ST_LSCAN: ctrl.op = kts_pkg::OP_ROTATE;
      ST_BSCAN: begin
        if (!(bdone && (cnt == '0))) begin
          ctrl.op = kts_pkg::OP_ROTATE;
        end
      end
      default: ctrl.op = kts_pkg::OP_HOLD;
    endcase
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    kts_cell #(
      .IDX   (k),
      .NW    (NW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .wr_idx    (req.entry_index),
      .wr_key    (req.key),
      .n_used    (n_used),
      .left_key  (cell_key[(k + DEPTH - 1) % DEPTH]),
      .left_gt   (cell_gt[(k + DEPTH - 1) % DEPTH]),
      .right_key (cell_key[(k + 1) % DEPTH]),
      .key       (cell_key[k]),
      .gt        (cell_gt[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      pc        <= '0;
      bdone     <= 1'b0;
      is_bin    <= 1'b0;
      res_found <= 1'b0;
      res_pos   <= '0;
      out_valid <= 1'b0;
      out_found <= 1'b0;
      out_pos   <= '0;
    end else begin
      if (rsp.valid && rsp.ready && (state != ST_PUSH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            skey      <= req.key;
            is_bin    <= (req.func == kts_pkg::FN_BSEARCH);
            res_found <= 1'b0;
            res_pos   <= '0;
            cnt       <= '0;
            pc        <= '0;
            bdone     <= 1'b0;
            low       <= '0;
            high      <= BW'(n_used) - BW'(1);
            case (req.func) inside
              kts_pkg::FN_SORT, kts_pkg::FN_BSEARCH: state <= ST_SORT;
              kts_pkg::FN_LSEARCH:                   state <= ST_LSCAN;
              default:                               state <= ST_IDLE;
            endcase
          end
        end
        ST_SORT: begin
          if (pc == IW'(DEPTH - 1)) begin
            pc    <= '0;
            state <= is_bin ? ST_BSCAN : ST_IDLE;
          end else begin
            pc <= pc + IW'(1);
          end
        end
        ST_LSCAN: begin
          if (!res_found && (NW'(cnt) < n_used) && (cell_key[0] == skey)) begin
            res_found <= 1'b1;
            res_pos   <= kts_pkg::INDEX_W'(cnt);
          end
          if (cnt == IW'(DEPTH - 1)) begin
            cnt   <= '0;
            state <= ST_PUSH;
          end else begin
            cnt <= cnt + IW'(1);
          end
        end
        ST_BSCAN: begin
          if (bdone && (cnt == '0)) begin
            state <= ST_PUSH;
          end else begin
            cnt <= (cnt == IW'(DEPTH - 1)) ? '0 : cnt + IW'(1);
            if (!bdone) begin
              if (low > high) begin
                bdone <= 1'b1;
              end else if (cnt == mid[IW-1:0]) begin
                if (cell_key[0] > skey) begin
                  high <= mid - BW'(1);
                end else if (skey > cell_key[0]) begin
                  low <= mid + BW'(1);
                end else begin
                  bdone     <= 1'b1;
                  res_found <= 1'b1;
                  res_pos   <= kts_pkg::INDEX_W'(mid[IW-1:0]);
                end
              end
            end
          end
        end
        ST_PUSH: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_found <= res_found;
            out_pos   <= res_pos;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ring_aligned_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cnt == '0))
    else $error("cell ring not aligned while idle");

  a_miss_position_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.position == '0))
    else $error("miss reported with nonzero position");

  a_write_single_cycle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.func == kts_pkg::FN_WRITE)) |=> (state == ST_IDLE))
    else $error("write did not complete in one cycle");

  a_sort_phase_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SORT) |-> (pc == '0))
    else $error("sort phase counter left running");
`endif

endmodule

`default_nettype wire
